FILE: rtl/core/scsc_pkg.sv
// Shared constants, item types and sequencer codes for the strongly connected sink counter.
package scsc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = 11;                    // node numbers 0..MAX_NODES
  localparam int CNT_W     = 13;                    // edge counts 0..MAX_EDGES
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int NODE_D    = MAX_NODES + 2;         // per-node tables, index up to n+1
  localparam int NODE_AW   = $clog2(NODE_D);
  localparam int STK_AW    = $clog2(MAX_NODES);
  localparam int EDGE_W    = 2 * NODE_W;
  localparam int FRAME_W   = NODE_W + CNT_W;
  localparam int ST_W      = 5;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic              edge_present;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] popular_count;
    logic [NODE_W-1:0] sink_components;
    logic              edges_dropped;
  } out_item_t;

  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_CLR   = 5'd1;
  localparam logic [ST_W-1:0] S_CNT_A = 5'd2;
  localparam logic [ST_W-1:0] S_CNT_B = 5'd3;
  localparam logic [ST_W-1:0] S_CNT_C = 5'd4;
  localparam logic [ST_W-1:0] S_PFX_A = 5'd5;
  localparam logic [ST_W-1:0] S_PFX_B = 5'd6;
  localparam logic [ST_W-1:0] S_FIL_A = 5'd7;
  localparam logic [ST_W-1:0] S_FIL_B = 5'd8;
  localparam logic [ST_W-1:0] S_FIL_C = 5'd9;
  localparam logic [ST_W-1:0] S_OUT_A = 5'd10;
  localparam logic [ST_W-1:0] S_OUT_B = 5'd11;
  localparam logic [ST_W-1:0] S_ENT_A = 5'd12;
  localparam logic [ST_W-1:0] S_ENT_B = 5'd13;
  localparam logic [ST_W-1:0] S_ENT_C = 5'd14;
  localparam logic [ST_W-1:0] S_LOOP  = 5'd15;
  localparam logic [ST_W-1:0] S_EDG_A = 5'd16;
  localparam logic [ST_W-1:0] S_EDG_B = 5'd17;
  localparam logic [ST_W-1:0] S_PCM_A = 5'd18;
  localparam logic [ST_W-1:0] S_PCM_B = 5'd19;
  localparam logic [ST_W-1:0] S_POP   = 5'd20;
  localparam logic [ST_W-1:0] S_POP_A = 5'd21;
  localparam logic [ST_W-1:0] S_POP_B = 5'd22;
  localparam logic [ST_W-1:0] S_MRK_A = 5'd23;
  localparam logic [ST_W-1:0] S_MRK_B = 5'd24;
  localparam logic [ST_W-1:0] S_MRK_C = 5'd25;
  localparam logic [ST_W-1:0] S_MRK_D = 5'd26;
  localparam logic [ST_W-1:0] S_SUM_A = 5'd27;
  localparam logic [ST_W-1:0] S_SUM_B = 5'd28;
  localparam logic [ST_W-1:0] S_FIN   = 5'd29;

  typedef struct packed {
    logic [ST_W-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic start;       // last item offered
    logic clr_end;     // index reached n+1
    logic edges_end;   // index reached stored edge total
    logic edge_ok;     // fetched edge lies inside 1..n
    logic nodes_end;   // index passed n
    logic vo_zero;     // fetched visit order is unvisited
    logic more_edges;  // top frame still has edges
    logic is_root;     // top node roots a component
    logic pop_more;    // component pop continues
    logic last_frame;  // one frame left on call stack
    logic out_busy;    // result register still full
  } stat_t;

endpackage

FILE: rtl/core/scsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/scsc_ctrl.sv
// Sequencer for load, adjacency build, component walk, marking and summing.
module scsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  scsc_pkg::stat_t stat,
  output scsc_pkg::cmd_t  cmd
);
  import scsc_pkg::*;

  logic [ST_W-1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (stat.start) state_nxt = S_CLR;
      S_CLR:   if (stat.clr_end) state_nxt = S_CNT_A;
      S_CNT_A: state_nxt = stat.edges_end ? S_PFX_A : S_CNT_B;
      S_CNT_B: state_nxt = stat.edge_ok ? S_CNT_C : S_CNT_A;
      S_CNT_C: state_nxt = S_CNT_A;
      S_PFX_A: state_nxt = S_PFX_B;
      S_PFX_B: state_nxt = stat.clr_end ? S_FIL_A : S_PFX_A;
      S_FIL_A: state_nxt = stat.edges_end ? S_OUT_A : S_FIL_B;
      S_FIL_B: state_nxt = stat.edge_ok ? S_FIL_C : S_FIL_A;
      S_FIL_C: state_nxt = S_FIL_A;
      S_OUT_A: state_nxt = stat.nodes_end ? S_MRK_A : S_OUT_B;
      S_OUT_B: state_nxt = stat.vo_zero ? S_ENT_A : S_OUT_A;
      S_ENT_A: state_nxt = S_ENT_B;
      S_ENT_B: state_nxt = S_ENT_C;
      S_ENT_C: state_nxt = S_LOOP;
      S_LOOP: begin
        if (stat.more_edges) state_nxt = S_EDG_A;
        else if (stat.is_root) state_nxt = S_PCM_A;
        else state_nxt = S_POP;
      end
      S_EDG_A: state_nxt = S_EDG_B;
      S_EDG_B: state_nxt = stat.vo_zero ? S_ENT_A : S_LOOP;
      S_PCM_A: state_nxt = S_PCM_B;
      S_PCM_B: state_nxt = stat.pop_more ? S_PCM_A : S_POP;
      S_POP:   state_nxt = stat.last_frame ? S_OUT_A : S_POP_A;
      S_POP_A: state_nxt = S_POP_B;
      S_POP_B: state_nxt = S_LOOP;
      S_MRK_A: state_nxt = stat.edges_end ? S_SUM_A : S_MRK_B;
      S_MRK_B: state_nxt = stat.edge_ok ? S_MRK_C : S_MRK_A;
      S_MRK_C: state_nxt = S_MRK_D;
      S_MRK_D: state_nxt = S_MRK_A;
      S_SUM_A: state_nxt = stat.nodes_end ? S_FIN : S_SUM_B;
      S_SUM_B: state_nxt = S_SUM_A;
      S_FIN:   if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.st = state_r;

endmodule

FILE: rtl/core/scsc_datapath.sv
// Edge store, per-node tables, explicit stacks and counters for the component walk.
module scsc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scsc_pkg::cmd_t             cmd,
  output scsc_pkg::stat_t            stat,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  scsc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output scsc_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scsc_pkg::NODE_W-1:0] cfg_data
);
  import scsc_pkg::*;

  logic [NODE_W-1:0]  ncount_r, n_eff;
  logic [CNT_W-1:0]   i_r, total_r, acc_r, start_r, top_pos_r, top_end_r;
  logic [NODE_W-1:0]  src_r, new_v_r, top_v_r, top_ll_r, top_vo_r, rs_r;
  logic [NODE_W-1:0]  nsp_r, csp_r, vc_r, ccnt_r, cnt_r, ans_r;
  logic               drop_r, out_valid_r;
  out_item_t          out_r;
  logic [ST_W-1:0]    st;
  logic               in_fire;

  logic [NODE_W-1:0]  e_src, e_dst;
  logic               e_ok;
  logic [CNT_W-1:0]   n_plus1;

  // RAM ports
  logic edg_we, edg_re, adj_we, adj_re, ls_we, ls_re, fil_we, fil_re;
  logic vo_we, vo_re, ll_we, ll_re, rt_we, rt_re, os_we, os_re;
  logic cs_we, cs_re, ho_we, ho_re, ns_we, ns_re, cst_we, cst_re;
  logic [EDGE_AW-1:0] edg_wa, edg_ra, adj_wa, adj_ra;
  logic [NODE_AW-1:0] ls_wa, ls_ra, fil_wa, fil_ra, vo_wa, vo_ra, ll_wa, ll_ra;
  logic [NODE_AW-1:0] rt_wa, rt_ra, os_wa, os_ra, cs_wa, cs_ra, ho_wa, ho_ra;
  logic [STK_AW-1:0]  ns_wa, ns_ra, cst_wa, cst_ra;
  logic [EDGE_W-1:0]  edg_wd, edg_rd;
  logic [NODE_W-1:0]  adj_wd, adj_rd, vo_wd, vo_rd, ll_wd, ll_rd, rt_wd, rt_rd;
  logic [NODE_W-1:0]  cs_wd, cs_rd, ns_wd, ns_rd;
  logic [CNT_W-1:0]   ls_wd, ls_rd, fil_wd, fil_rd;
  logic               os_wd, os_rd, ho_wd, ho_rd;
  logic [FRAME_W-1:0] cst_wd, cst_rd;

  assign st        = cmd.st;
  assign in_ready  = (st == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (ncount_r == '0) n_eff = NODE_W'(1);
    else if (ncount_r > NODE_W'(MAX_NODES)) n_eff = NODE_W'(MAX_NODES);
    else n_eff = ncount_r;
  end

  assign n_plus1 = CNT_W'(n_eff) + CNT_W'(1);
  assign e_src   = edg_rd[EDGE_W-1:NODE_W];
  assign e_dst   = edg_rd[NODE_W-1:0];
  assign e_ok    = (e_src <= n_eff) && (e_dst <= n_eff);

  always_comb begin
    stat.start      = in_valid && in_data.last_edge;
    stat.clr_end    = (i_r == n_plus1);
    stat.edges_end  = (i_r == total_r);
    stat.edge_ok    = e_ok;
    stat.nodes_end  = (i_r > CNT_W'(n_eff));
    stat.vo_zero    = (vo_rd == '0);
    stat.more_edges = (top_pos_r < top_end_r);
    stat.is_root    = (top_ll_r == top_vo_r);
    stat.pop_more   = (ns_rd != top_v_r) && (nsp_r != '0);
    stat.last_frame = (csp_r == NODE_W'(1));
    stat.out_busy   = out_valid_r;
  end

  // RAM port steering
  always_comb begin
    edg_we = 1'b0; edg_wa = total_r[EDGE_AW-1:0];
    edg_wd = {in_data.src_node, in_data.dst_node};
    edg_re = 1'b0; edg_ra = i_r[EDGE_AW-1:0];
    adj_we = 1'b0; adj_wa = fil_rd[EDGE_AW-1:0]; adj_wd = e_dst;
    adj_re = 1'b0; adj_ra = top_pos_r[EDGE_AW-1:0];
    ls_we = 1'b0; ls_wa = i_r[NODE_AW-1:0]; ls_wd = '0;
    ls_re = 1'b0; ls_ra = i_r[NODE_AW-1:0];
    fil_we = 1'b0; fil_wa = i_r[NODE_AW-1:0]; fil_wd = acc_r + ls_rd;
    fil_re = 1'b0; fil_ra = NODE_AW'(e_src);
    vo_we = 1'b0; vo_wa = i_r[NODE_AW-1:0]; vo_wd = '0;
    vo_re = 1'b0; vo_ra = i_r[NODE_AW-1:0];
    ll_we = 1'b0; ll_wa = NODE_AW'(top_v_r); ll_wd = top_ll_r;
    ll_re = 1'b0; ll_ra = NODE_AW'(cst_rd[FRAME_W-1:CNT_W]);
    rt_we = 1'b0; rt_wa = NODE_AW'(ns_rd); rt_wd = top_v_r;
    rt_re = 1'b0; rt_ra = i_r[NODE_AW-1:0];
    os_we = 1'b0; os_wa = i_r[NODE_AW-1:0]; os_wd = 1'b0;
    os_re = 1'b0; os_ra = NODE_AW'(adj_rd);
    cs_we = 1'b0; cs_wa = i_r[NODE_AW-1:0]; cs_wd = '0;
    cs_re = 1'b0; cs_ra = i_r[NODE_AW-1:0];
    ho_we = 1'b0; ho_wa = i_r[NODE_AW-1:0]; ho_wd = 1'b0;
    ho_re = 1'b0; ho_ra = i_r[NODE_AW-1:0];
    ns_we = 1'b0; ns_wa = nsp_r[STK_AW-1:0]; ns_wd = new_v_r;
    ns_re = 1'b0; ns_ra = STK_AW'(nsp_r - NODE_W'(1));
    cst_we = 1'b0; cst_wa = STK_AW'(csp_r - NODE_W'(1)); cst_wd = {top_v_r, top_pos_r};
    cst_re = 1'b0; cst_ra = STK_AW'(csp_r - NODE_W'(2));
    case (st)
      S_IDLE: begin
        edg_we = in_fire && in_data.edge_present && (in_data.src_node != '0) &&
                 (in_data.dst_node != '0) && (in_data.src_node <= n_eff) &&
                 (in_data.dst_node <= n_eff) && (total_r < CNT_W'(MAX_EDGES));
      end
      S_CLR: begin
        ls_we = 1'b1; vo_we = 1'b1; os_we = 1'b1; cs_we = 1'b1; ho_we = 1'b1;
      end
      S_CNT_A, S_FIL_A, S_MRK_A: edg_re = !stat.edges_end;
      S_CNT_B: begin
        ls_re = e_ok;
        ls_ra = NODE_AW'(e_src + NODE_W'(1));
      end
      S_CNT_C: begin
        ls_we = 1'b1;
        ls_wa = NODE_AW'(src_r + NODE_W'(1));
        ls_wd = ls_rd + CNT_W'(1);
      end
      S_PFX_A: ls_re = 1'b1;
      S_PFX_B: begin
        ls_we = 1'b1; ls_wd = acc_r + ls_rd; fil_we = 1'b1;
      end
      S_FIL_B: fil_re = e_ok;
      S_FIL_C: begin
        adj_we = 1'b1;
        fil_we = 1'b1; fil_wa = NODE_AW'(src_r); fil_wd = fil_rd + CNT_W'(1);
      end
      S_OUT_A: vo_re = !stat.nodes_end;
      S_ENT_A: begin
        ls_re = 1'b1; ls_ra = NODE_AW'(new_v_r);
      end
      S_ENT_B: begin
        ls_re = 1'b1; ls_ra = NODE_AW'(new_v_r + NODE_W'(1));
      end
      S_ENT_C: begin
        vo_we = 1'b1; vo_wa = NODE_AW'(new_v_r); vo_wd = vc_r + NODE_W'(1);
        os_we = 1'b1; os_wa = NODE_AW'(new_v_r); os_wd = 1'b1;
        ns_we = 1'b1;
      end
      S_LOOP: adj_re = stat.more_edges;
      S_EDG_A: begin
        vo_re = 1'b1; vo_ra = NODE_AW'(adj_rd); os_re = 1'b1;
      end
      S_EDG_B: begin
        // push: spill the current top frame and its low link
        cst_we = stat.vo_zero; ll_we = stat.vo_zero;
      end
      S_PCM_A: ns_re = 1'b1;
      S_PCM_B: begin
        os_we = 1'b1; os_wa = NODE_AW'(ns_rd);
        rt_we = 1'b1;
        cs_we = !stat.pop_more; cs_wa = NODE_AW'(top_v_r); cs_wd = ccnt_r + NODE_W'(1);
      end
      S_POP: cst_re = !stat.last_frame;
      S_POP_A: begin
        ll_re = 1'b1;
        vo_re = 1'b1; vo_ra = NODE_AW'(cst_rd[FRAME_W-1:CNT_W]);
        ls_re = 1'b1; ls_ra = NODE_AW'(cst_rd[FRAME_W-1:CNT_W] + NODE_W'(1));
      end
      S_MRK_B: begin
        rt_re = e_ok; rt_ra = NODE_AW'(e_src);
      end
      S_MRK_C: begin
        rt_re = 1'b1; rt_ra = NODE_AW'(e_dst);
      end
      S_MRK_D: begin
        ho_we = (rs_r != rt_rd); ho_wa = NODE_AW'(rs_r); ho_wd = 1'b1;
      end
      S_SUM_A: begin
        rt_re = !stat.nodes_end; ho_re = !stat.nodes_end; cs_re = !stat.nodes_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r    <= NODE_W'(1);
      total_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      nsp_r       <= '0;
      csp_r       <= '0;
      vc_r        <= '0;
      i_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) ncount_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in_fire && in_data.edge_present) begin
            if (edg_we) total_r <= total_r + CNT_W'(1);
            else drop_r <= 1'b1;
          end
          if (stat.start) begin
            i_r <= '0; nsp_r <= '0; csp_r <= '0; vc_r <= '0;
          end
        end
        S_CLR: i_r <= stat.clr_end ? '0 : i_r + CNT_W'(1);
        S_CNT_A: if (stat.edges_end) begin
          i_r <= '0; acc_r <= '0;
        end
        S_CNT_B: begin
          src_r <= e_src;
          if (!e_ok) begin
            drop_r <= 1'b1; i_r <= i_r + CNT_W'(1);
          end
        end
        S_CNT_C, S_FIL_C, S_MRK_D, S_SUM_B: i_r <= i_r + CNT_W'(1);
        S_PFX_B: begin
          acc_r <= acc_r + ls_rd;
          i_r   <= stat.clr_end ? '0 : i_r + CNT_W'(1);
        end
        S_FIL_A: if (stat.edges_end) i_r <= CNT_W'(1);
        S_FIL_B: begin
          src_r <= e_src;
          if (!e_ok) i_r <= i_r + CNT_W'(1);
        end
        S_OUT_A: if (stat.nodes_end) i_r <= '0;
        S_OUT_B: begin
          if (stat.vo_zero) new_v_r <= i_r[NODE_W-1:0];
          else i_r <= i_r + CNT_W'(1);
        end
        S_ENT_B: start_r <= ls_rd;
        S_ENT_C: begin
          top_v_r   <= new_v_r;
          top_pos_r <= start_r;
          top_end_r <= ls_rd;
          top_ll_r  <= vc_r + NODE_W'(1);
          top_vo_r  <= vc_r + NODE_W'(1);
          vc_r      <= vc_r + NODE_W'(1);
          nsp_r     <= nsp_r + NODE_W'(1);
          csp_r     <= csp_r + NODE_W'(1);
        end
        S_LOOP: begin
          if (stat.more_edges) top_pos_r <= top_pos_r + CNT_W'(1);
          ccnt_r <= '0;
        end
        S_EDG_B: begin
          if (stat.vo_zero) new_v_r <= adj_rd;
          else if (os_rd && (vo_rd < top_ll_r)) top_ll_r <= vo_rd;
        end
        S_PCM_A: nsp_r <= nsp_r - NODE_W'(1);
        S_PCM_B: ccnt_r <= ccnt_r + NODE_W'(1);
        S_POP: begin
          csp_r <= csp_r - NODE_W'(1);
          if (stat.last_frame) i_r <= i_r + CNT_W'(1);
        end
        S_POP_A: begin
          top_v_r   <= cst_rd[FRAME_W-1:CNT_W];
          top_pos_r <= cst_rd[CNT_W-1:0];
        end
        S_POP_B: begin
          // fold the finished child's low link into the parent
          if (ll_rd < top_ll_r) top_ll_r <= ll_rd;
          top_vo_r  <= vo_rd;
          top_end_r <= ls_rd;
        end
        S_MRK_A: if (stat.edges_end) begin
          i_r <= CNT_W'(1); cnt_r <= '0; ans_r <= '0;
        end
        S_MRK_B: if (!e_ok) i_r <= i_r + CNT_W'(1);
        S_MRK_C: rs_r <= rt_rd;
        S_SUM_A: ;
        S_FIN: if (!out_valid_r) begin
          out_valid_r <= 1'b1;
          total_r     <= '0;
          drop_r      <= 1'b0;
        end
        default: ;
      endcase
      if (st == S_SUM_B && rt_rd == i_r[NODE_W-1:0] && !ho_rd) begin
        cnt_r <= cnt_r + NODE_W'(1);
        ans_r <= ans_r + cs_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FIN && !out_valid_r) begin
      out_r.popular_count   <= (cnt_r >= NODE_W'(2)) ? '0 : ans_r;
      out_r.sink_components <= cnt_r;
      out_r.edges_dropped   <= drop_r;
    end
  end

  scsc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(edg_we), .waddr(edg_wa), .wdata(edg_wd), .re(edg_re), .raddr(edg_ra),
    .rdata(edg_rd));
  scsc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_adj (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .re(adj_re), .raddr(adj_ra),
    .rdata(adj_rd));
  scsc_ram #(.WIDTH(CNT_W), .DEPTH(NODE_D)) u_lstart (
    .clk, .we(ls_we), .waddr(ls_wa), .wdata(ls_wd), .re(ls_re), .raddr(ls_ra),
    .rdata(ls_rd));
  scsc_ram #(.WIDTH(CNT_W), .DEPTH(NODE_D)) u_fill (
    .clk, .we(fil_we), .waddr(fil_wa), .wdata(fil_wd), .re(fil_re), .raddr(fil_ra),
    .rdata(fil_rd));
  scsc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_D)) u_vorder (
    .clk, .we(vo_we), .waddr(vo_wa), .wdata(vo_wd), .re(vo_re), .raddr(vo_ra),
    .rdata(vo_rd));
  scsc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_D)) u_llink (
    .clk, .we(ll_we), .waddr(ll_wa), .wdata(ll_wd), .re(ll_re), .raddr(ll_ra),
    .rdata(ll_rd));
  scsc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_D)) u_root (
    .clk, .we(rt_we), .waddr(rt_wa), .wdata(rt_wd), .re(rt_re), .raddr(rt_ra),
    .rdata(rt_rd));
  scsc_ram #(.WIDTH(1), .DEPTH(NODE_D)) u_onstk (
    .clk, .we(os_we), .waddr(os_wa), .wdata(os_wd), .re(os_re), .raddr(os_ra),
    .rdata(os_rd));
  scsc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_D)) u_csize (
    .clk, .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .re(cs_re), .raddr(cs_ra),
    .rdata(cs_rd));
  scsc_ram #(.WIDTH(1), .DEPTH(NODE_D)) u_hasout (
    .clk, .we(ho_we), .waddr(ho_wa), .wdata(ho_wd), .re(ho_re), .raddr(ho_ra),
    .rdata(ho_rd));
  scsc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_nstack (
    .clk, .we(ns_we), .waddr(ns_wa), .wdata(ns_wd), .re(ns_re), .raddr(ns_ra),
    .rdata(ns_rd));
  scsc_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES)) u_cstack (
    .clk, .we(cst_we), .waddr(cst_wa), .wdata(cst_wd), .re(cst_re), .raddr(cst_ra),
    .rdata(cst_rd));

  // every open frame sits on the node stack, bar a root whose component was just popped
  a_frames_le_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    csp_r <= nsp_r + NODE_W'(1)) else $error("call stack deeper than node stack");
  a_idle_no_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (st == S_IDLE) |-> (csp_r == '0)) else $error("call frames left after walk");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st == S_ENT_C) |-> (nsp_r < NODE_W'(MAX_NODES))) else $error("node stack overflow");
  a_visit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st == S_MRK_A) |-> (vc_r <= n_eff)) else $error("visit count exceeds node count");

endmodule

FILE: rtl/core/strongly_connected_sink_count_top.sv
// Top level of the strongly connected sink counter: sequencer plus datapath.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_item_t  (one edge per item)
//   out_     output     out_valid / out_ready  out_item_t (one per last item)
//   cfg_     input      cfg_valid / cfg_ready  node_count, 11 bits
//
// Edges load at one item per cycle. An item with last_edge starts analysis, during
// which input stalls while the clear sweep, count, prefix, fill, walk, mark and sum
// phases run in turn, each RAM having a single read port. Synchronous active-low reset;
// node_count resets to 1. The result stays registered until taken and the next graph
// may load meanwhile.
module strongly_connected_sink_count_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  scsc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scsc_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scsc_pkg::NODE_W-1:0] cfg_data
);
  import scsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  scsc_ctrl u_ctrl (
    .clk, .rst_n, .stat, .cmd
  );

  scsc_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

endmodule
